// ----- rtl/core/sorted_set_insert_delete_dump_assert.svh -----
// Assertion macros for the sorted set block.
// Included by the top level; depends on nothing else.
`ifndef SORTED_SET_INSERT_DELETE_DUMP_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_DUMP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSIDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSIDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ssidd_pkg.sv -----
// Shared types and codes for the sorted set block.
// Used by the channel interfaces, the cell and the top level.
package ssidd_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int CAPACITY_DEF = 16;

  // Input word kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ASC    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DESC   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

  // Operation broadcast to every cell in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } cell_op_t;

  // Control word shared by all cells.
  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   value;
    logic [DATA_W-1:0]   wrap;
  } cell_ctl_t;

endpackage

// ----- rtl/core/ssidd_if.sv -----
// Valid/ready channel interfaces for the sorted set block.
// Depends on ssidd_pkg for field widths.
interface ssidd_in_if import ssidd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source(output valid, kind, value, input ready);
  modport sink(input valid, kind, value, output ready);
endinterface

interface ssidd_out_if import ssidd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] item_value;
  logic                     last;

  modport source(output valid, status, item_value, last, input ready);
  modport sink(input valid, status, item_value, last, output ready);
endinterface

// ----- rtl/core/ssidd_cell.sv -----
// One storage cell of the sorted chain: holds a value and trades it with its neighbors.
// Depends on ssidd_pkg for the control word.
module ssidd_cell import ssidd_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occupied,
  input  logic              is_tail,
  input  logic              left_lt,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val,
  output logic              lt,
  output logic              eq
);

  logic [DATA_W-1:0] val_next;

  // Compare the stored value against the broadcast value.
  assign lt = occupied && ($signed(val) < $signed(ctl.value));
  assign eq = occupied && (val == ctl.value);

  // Past the insert point cells shift right, past the delete point left; dumps rotate.
  always_comb begin
    val_next = val;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (!lt) val_next = left_lt ? ctl.value : left_val;
      end
      CELL_DELETE: begin
        if (!lt) val_next = right_val;
      end
      CELL_ROT_LEFT: begin
        if (occupied) val_next = is_tail ? ctl.wrap : right_val;
      end
      CELL_ROT_RIGHT: begin
        if (occupied) val_next = FIRST ? ctl.wrap : left_val;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ----- rtl/core/sorted_set_insert_delete_dump.sv -----
// Sorted set of distinct signed values held in a chain of compare-and-shift cells.
// Insert and delete: status word valid in the cycle after the input word is taken.
// Emit: one entry word per cycle while the sink is ready; the first one passes the dump
// state and then the output register. The input side is held while the chain rotates,
// longer while the sink stalls. Reset clears the count, the dump state and the output
// valid; cell values are kept.
module sorted_set_insert_delete_dump import ssidd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ssidd_in_if.sink    req,
  ssidd_out_if.source rsp
);

  `include "sorted_set_insert_delete_dump_assert.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       remain;
  logic                dumping;
  logic                desc;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [DATA_W-1:0]   rsp_item;
  logic                rsp_last;

  logic [DATA_W-1:0]   vals      [CAPACITY];
  logic [DATA_W-1:0]   left_val  [CAPACITY];
  logic [DATA_W-1:0]   right_val [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] left_lt;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] tail;

  logic              out_free;
  logic              accept;
  logic              step;
  logic              found;
  logic              full;
  logic              do_ins;
  logic              do_del;
  logic [DATA_W-1:0] tail_val;
  logic [DATA_W-1:0] wrap;
  cell_ctl_t         ctl;

  // Handshake and decode.
  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = !dumping && out_free;
  assign accept    = req.valid && req.ready;
  assign step      = dumping && out_free;
  assign found     = |eq;
  assign full      = (count == CW'(CAPACITY));
  assign do_ins    = accept && (req.kind == KIND_INSERT) && !found && !full;
  assign do_del    = accept && (req.kind == KIND_DELETE) && found;

  // Value that leaves the chain in a dump cycle: head going up, tail going down.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_val = tail_val | (tail[i] ? vals[i] : '0);
    end
  end
  assign wrap = desc ? tail_val : vals[0];

  // Control word for every cell.
  always_comb begin
    ctl.value = req.value;
    ctl.wrap  = wrap;
    priority if (do_ins) begin
      ctl.op = CELL_INSERT;
    end else if (do_del) begin
      ctl.op = CELL_DELETE;
    end else if (step) begin
      ctl.op = desc ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
    end else begin
      ctl.op = CELL_HOLD;
    end
  end

  // The chain of cells, each linked to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]  = (CW'(i) < count);
    assign tail[i] = (count == CW'(i + 1));

    if (i == 0) begin : g_head
      assign left_lt[i]  = 1'b1;
      assign left_val[i] = '0;
    end else begin : g_left
      assign left_lt[i]  = lt[i-1];
      assign left_val[i] = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val[i] = '0;
    end else begin : g_right
      assign right_val[i] = vals[i+1];
    end

    ssidd_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ[i]),
      .is_tail   (tail[i]),
      .left_lt   (left_lt[i]),
      .left_val  (left_val[i]),
      .right_val (right_val[i]),
      .val       (vals[i]),
      .lt        (lt[i]),
      .eq        (eq[i])
    );
  end

  // Count, dump sequencing and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remain    <= '0;
      dumping   <= 1'b0;
      desc      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        rsp_item <= '0;
        rsp_last <= 1'b1;
        unique case (req.kind)
          KIND_INSERT: begin
            rsp_valid <= 1'b1;
            if (found) begin
              rsp_status <= ST_DUP;
            end else if (full) begin
              rsp_status <= ST_FULL;
            end else begin
              rsp_status <= ST_DONE;
              count      <= count + CW'(1);
            end
          end
          KIND_DELETE: begin
            rsp_valid <= 1'b1;
            if (found) begin
              rsp_status <= ST_DONE;
              count      <= count - CW'(1);
            end else begin
              rsp_status <= ST_MISSING;
            end
          end
          KIND_ASC, KIND_DESC: begin
            desc <= (req.kind == KIND_DESC);
            if (count == '0) begin
              rsp_valid  <= 1'b1;
              rsp_status <= ST_EMPTY;
            end else begin
              rsp_valid <= 1'b0;
              dumping   <= 1'b1;
              remain    <= count;
            end
          end
          default: rsp_valid <= 1'b0;
        endcase
      end else if (step) begin
        rsp_valid  <= 1'b1;
        rsp_status <= ST_ENTRY;
        rsp_item   <= wrap;
        rsp_last   <= (remain == CW'(1));
        remain     <= remain - CW'(1);
        if (remain == CW'(1)) dumping <= 1'b0;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.item_value = rsp_item;
  assign rsp.last       = rsp_last;

  // Checks on the count and the dump sequence.
  `SSIDD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "count over capacity")
  `SSIDD_ASSERT_NEXT(a_dump_keeps_count, clk, rst, dumping, count == $past(count), "count moved in dump")
  `SSIDD_ASSERT_NEXT(a_insert_grows, clk, rst, do_ins, count == $past(count) + CW'(1), "insert lost")
  `SSIDD_ASSERT_NOW(a_dump_has_work, clk, rst, dumping, remain != '0, "dump with no entries")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for sorted_set_insert_delete_dump: an in-bench model of the sorted set checks
// every status and entry word in order. Depends on ssidd_pkg, the ssidd_if channels and the
// top level.
module tb;
  import ssidd_pkg::*;

  localparam int SET_CAP       = CAPACITY_DEF;
  localparam int POOL_SIZE     = 24;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TIMEOUT_NS    = 8_000_000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
  } set_result_t;

  logic clk;
  logic rst;

  ssidd_in_if  req_ch ();
  ssidd_out_if rsp_ch ();

  sorted_set_insert_delete_dump #(
    .CAPACITY(SET_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the set, updated when the block takes each input word.
  logic signed [DATA_W-1:0] shadow_entries [SET_CAP];
  int                       shadow_count;
  set_result_t              pending_results [$];
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];
  int                       mismatch_count;
  bit                       no_idle;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("sorted_set_insert_delete_dump verification failed");
    $finish;
  end

  function automatic void push_result(input logic [STATUS_W-1:0] st,
                                      input logic signed [DATA_W-1:0] val,
                                      input logic lst);
    set_result_t r;
    r.status     = st;
    r.item_value = val;
    r.last       = lst;
    pending_results.push_back(r);
  endfunction

  // Works out the words that one input word causes and updates the shadow set.
  function automatic void predict_set_results(input logic [KIND_W-1:0] k,
                                              input logic signed [DATA_W-1:0] v);
    int  pos;
    int  i;
    bit  hit;
    pos = 0;
    while (pos < shadow_count && shadow_entries[pos] < v) pos++;
    hit = (pos < shadow_count) && (shadow_entries[pos] == v);
    case (k)
      KIND_INSERT: begin
        // The duplicate check wins over the full check.
        if (hit) begin
          push_result(ST_DUP, '0, 1'b1);
        end else if (shadow_count >= SET_CAP) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = v;
          shadow_count++;
          push_result(ST_DONE, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
          push_result(ST_DONE, '0, 1'b1);
        end else begin
          push_result(ST_MISSING, '0, 1'b1);
        end
      end
      KIND_ASC, KIND_DESC: begin
        if (shadow_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            push_result(ST_ENTRY,
                        shadow_entries[(k == KIND_ASC) ? i : shadow_count - 1 - i],
                        (i + 1 == shadow_count));
          end
        end
      end
    endcase
  endfunction

  // Idle length before an input word: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(8, 4);
    return $urandom_range(40, 15);
  endfunction

  // Sends one input word and predicts its results at the accepting edge.
  task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.value <= v;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    predict_set_results(k, v);
  endtask

  // Value choice: a small pool so that duplicates and hits are common, stored values,
  // and full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_value(input bit prefer_stored);
    int r;
    r = $urandom_range(99);
    if (prefer_stored && shadow_count > 0 && r < 60)
      return shadow_entries[$urandom_range(shadow_count - 1)];
    if (r < 75) return value_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 85 && shadow_count > 0) return shadow_entries[$urandom_range(shadow_count - 1)];
    return $urandom;
  endfunction

  task automatic run_random_ops(input int n_words, input int insert_pct, input int delete_pct);
    int               r;
    logic [KIND_W-1:0] k;
    repeat (n_words) begin
      r = $urandom_range(99);
      if (r < insert_pct) k = KIND_INSERT;
      else if (r < insert_pct + delete_pct) k = KIND_DELETE;
      else k = $urandom_range(1) ? KIND_ASC : KIND_DESC;
      send_word(k, (k == KIND_DELETE) ? pick_value(1'b1) : pick_value(1'b0));
    end
  endtask

  // Emit and delete on a set that holds nothing.
  task automatic test_empty_set();
    send_word(KIND_ASC, $urandom);
    send_word(KIND_DESC, $urandom);
    send_word(KIND_DELETE, 32'sd0);
  endtask

  // Extremes of the value range, a duplicate, both dump orders and a missed delete.
  task automatic test_extreme_values();
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_INSERT, VAL_MIN);
    send_word(KIND_INSERT, 32'sd0);
    send_word(KIND_INSERT, -32'sd1);
    send_word(KIND_INSERT, 32'sd1);
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_ASC, 32'sd0);
    send_word(KIND_DESC, VAL_MIN);
    send_word(KIND_DELETE, VAL_MIN);
    send_word(KIND_DELETE, 32'sd2);
  endtask

  // Fill the set, then try a new value and a duplicate against the full set.
  task automatic test_fill_to_capacity();
    int n;
    n = 0;
    no_idle = 1'b1;
    while (shadow_count < SET_CAP) begin
      send_word(KIND_INSERT, 32'sd100 + 32'sd7 * n - 32'sd50 * (n % 3));
      n++;
    end
    no_idle = 1'b0;
    send_word(KIND_INSERT, -32'sd12345);
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_DESC, 32'sd0);
  endtask

  task automatic test_random_growth();
    run_random_ops(70, 60, 20);
  endtask

  task automatic test_random_shrink();
    run_random_ops(60, 20, 65);
  endtask

  task automatic test_random_back_to_back();
    no_idle = 1'b1;
    run_random_ops(70, 40, 40);
    no_idle = 1'b0;
  endtask

  // Output side stalls: runs of ready high and low, most low runs short.
  initial begin
    int stall_left;
    bit ready_now;
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    ready_now    = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if ($urandom_range(99) < 65) begin
          ready_now  = 1'b1;
          stall_left = $urandom_range(12, 1);
        end else begin
          ready_now  = 1'b0;
          stall_left = ($urandom_range(99) < 85) ? $urandom_range(3, 1)
                                                 : $urandom_range(40, 10);
        end
      end
      stall_left--;
      rsp_ch.ready <= no_idle ? 1'b1 : ready_now;
    end
  end

  // Compares each accepted output word with the oldest expectation.
  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: status %0d item_value %0d last %0d",
               rsp_ch.status, rsp_ch.item_value, rsp_ch.last);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.item_value !== exp_r.item_value) begin
          $error("item_value: expected %0d actual %0d", exp_r.item_value, rsp_ch.item_value);
          mismatch_count++;
        end
        if (rsp_ch.last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, rsp_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    int guard;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_INSERT;
    req_ch.value   = '0;
    shadow_count   = 0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_set();
    test_extreme_values();
    test_fill_to_capacity();

    // The pool holds the extremes, near neighbors and random values.
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    value_pool[5] = value_pool[4] + 32'sd1;
    test_random_shrink();
    test_random_growth();
    test_random_back_to_back();

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Wait for the last words, then keep watching the output to catch strays.
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected words never arrived", pending_results.size());
      mismatch_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("sorted_set_insert_delete_dump verification clean");
    else
      $display("sorted_set_insert_delete_dump verification failed");
    $finish;
  end

endmodule
